/* src/tjs_pkg.sv */
`default_nettype none

package tjs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int NUM_W     = DATA_W + 2;
   localparam int MAG_W     = NUM_W - 1;
   localparam int QUO_W     = DATA_W + 1;
   localparam int DVD_W     = MAG_W + FRAC_BITS;
   localparam int TOP_W     = DVD_W - QUO_W;
   localparam int CNT_W     = $clog2(QUO_W);
   localparam int TRIAL_W   = DATA_W + 2;

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_SUB,
      ST_MUL_SUP,
      ST_SUM,
      ST_SETUP,
      ST_DIV,
      ST_DONE
   } state_type;

   // floor shift of a full product, saturated to the data width
   function automatic logic [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] sh;
      logic [PROD_W-DATA_W:0]   hi;
      sh = p >>> FRAC_BITS;
      hi = sh[PROD_W-1:DATA_W-1];
      if ((&hi) || (~|hi)) begin
         sat_prod = sh[DATA_W-1:0];
      end else if (sh[PROD_W-1]) begin
         sat_prod = DATA_MIN;
      end else begin
         sat_prod = DATA_MAX;
      end
   endfunction

endpackage

`default_nettype wire

/* src/tridiagonal_jacobi_sweep.sv */
// Tridiagonal Jacobi sweep, signed Q16.16.
// Request channel (req_*): one word per matrix row, with req_last_row set on
// the final row of a vector. Response channel (rsp_*): one word per row, one
// row late; the word that carries req_last_row yields the previous row's
// response, if a row is held, and then its own (rsp_last_out set).
// A row response is computed in two passes through one 32x32 multiplier,
// a numerator sum, a setup step, a restoring divider that makes one
// quotient bit per cycle for 33 quotient bits, and a final step. A zero
// diagonal (0 with rsp_zero_diag set) or a quotient out of range skips
// the divider. The final row's own result first takes an extra load step.
// When the final step loads the response register and no final row waits,
// the sequencer returns to idle and the next word can be taken in the cycle
// after; a word that only starts a vector is held without a computation.
// req_stall is high while a result is computed, even if a response waits.
// A stalled response holds the sequencer in its final step, so nothing is
// dropped. Reset is synchronous: it empties the response register and
// forgets any row held from an unfinished vector.
`default_nettype none

module tridiagonal_jacobi_sweep import tjs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [DATA_W-1:0] req_rhs,
   input  wire logic [DATA_W-1:0] req_diag_coef,
   input  wire logic [DATA_W-1:0] req_sub_coef,
   input  wire logic [DATA_W-1:0] req_super_coef,
   input  wire logic [DATA_W-1:0] req_x_old,
   input  wire logic              req_last_row,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [DATA_W-1:0] rsp_x_new,
   output      logic              rsp_zero_diag,
   output      logic              rsp_last_out
);

   state_type state_ff, state_in;

   logic row_pending_ff, row_pending_in;
   logic tail_ff, tail_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [DATA_W-1:0] held_rhs_ff, held_rhs_in;
   logic [DATA_W-1:0] held_diag_ff, held_diag_in;
   logic [DATA_W-1:0] held_sub_ff, held_sub_in;
   logic [DATA_W-1:0] held_super_ff, held_super_in;
   logic [DATA_W-1:0] held_x_ff, held_x_in;
   logic [DATA_W-1:0] before_x_ff, before_x_in;

   logic [DATA_W-1:0] job_rhs_ff, job_rhs_in;
   logic [DATA_W-1:0] job_diag_ff, job_diag_in;
   logic [DATA_W-1:0] job_sub_ff, job_sub_in;
   logic [DATA_W-1:0] job_xp_ff, job_xp_in;
   logic [DATA_W-1:0] job_sup_ff, job_sup_in;
   logic [DATA_W-1:0] job_xn_ff, job_xn_in;
   logic              job_last_ff, job_last_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0]        p_sub_ff, p_sub_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dm_ff, dm_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic              ovf_ff, ovf_in;
   logic              zd_ff, zd_in;

   logic [DATA_W-1:0] rsp_x_new_ff, rsp_x_new_in;
   logic              rsp_zero_diag_ff, rsp_zero_diag_in;
   logic              rsp_last_out_ff, rsp_last_out_in;

   logic accept;
   logic out_free;
   logic load_rsp;

   logic [DATA_W-1:0]        mul_a;
   logic [DATA_W-1:0]        mul_b;
   logic [DATA_W-1:0]        p_sup;
   logic [NUM_W-1:0]         mag;
   logic [DVD_W-1:0]         dvd;
   logic [DATA_W-1:0]        dm_calc;
   logic [TOP_W-1:0]         top;
   logic [TRIAL_W-1:0]       trial;
   logic [QUO_W-1:0]         quo_neg;
   logic [DATA_W-1:0]        result;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (row_pending_ff) begin
                  state_in = ST_MUL_SUB;
               end else if (req_last_row) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD:    state_in = ST_MUL_SUB;
         ST_MUL_SUB: state_in = ST_MUL_SUP;
         ST_MUL_SUP: state_in = ST_SUM;
         ST_SUM:     state_in = ST_SETUP;
         ST_SETUP: begin
            if (job_diag_ff == '0 || ovf_in) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = tail_ff ? ST_LOAD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && (state_ff == ST_IDLE);
      load_rsp  = (state_ff == ST_DONE) && out_free;
   end

   // arithmetic
   always_comb begin
      mul_a   = (state_ff == ST_MUL_SUB) ? job_sub_ff : job_sup_ff;
      mul_b   = (state_ff == ST_MUL_SUB) ? job_xp_ff : job_xn_ff;
      p_sup   = sat_prod(prod_ff);
      mag     = num_ff[NUM_W-1] ? (NUM_W'(0) - num_ff) : num_ff;
      dvd     = {mag[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      top     = dvd[DVD_W-1:QUO_W];
      dm_calc = job_diag_ff[DATA_W-1] ? (DATA_W'(0) - job_diag_ff) : job_diag_ff;
      trial   = {1'b0, rem_ff, low_ff[QUO_W-1]} - {2'b00, dm_ff};
      quo_neg = QUO_W'(0) - quo_ff;
      if (zd_ff) begin
         result = '0;
      end else if (ovf_ff) begin
         result = neg_ff ? DATA_MIN : DATA_MAX;
      end else if (neg_ff) begin
         if (quo_ff[QUO_W-1] || (quo_ff[DATA_W-1] && (|quo_ff[DATA_W-2:0]))) begin
            result = DATA_MIN;
         end else begin
            result = quo_neg[DATA_W-1:0];
         end
      end else begin
         if (quo_ff[QUO_W-1] || quo_ff[DATA_W-1]) begin
            result = DATA_MAX;
         end else begin
            result = quo_ff[DATA_W-1:0];
         end
      end
   end

   // register next values
   always_comb begin
      row_pending_in = row_pending_ff;
      tail_in        = tail_ff;
      held_rhs_in    = held_rhs_ff;
      held_diag_in   = held_diag_ff;
      held_sub_in    = held_sub_ff;
      held_super_in  = held_super_ff;
      held_x_in      = held_x_ff;
      before_x_in    = before_x_ff;
      job_rhs_in     = job_rhs_ff;
      job_diag_in    = job_diag_ff;
      job_sub_in     = job_sub_ff;
      job_xp_in      = job_xp_ff;
      job_sup_in     = job_sup_ff;
      job_xn_in      = job_xn_ff;
      job_last_in    = job_last_ff;
      prod_in        = prod_ff;
      p_sub_in       = p_sub_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      dm_in          = dm_ff;
      low_in         = low_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      neg_in         = neg_ff;
      ovf_in         = ovf_ff;
      zd_in          = zd_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_x_new_in     = rsp_x_new_ff;
      rsp_zero_diag_in = rsp_zero_diag_ff;
      rsp_last_out_in  = rsp_last_out_ff;

      if (accept) begin
         if (row_pending_ff) begin
            job_rhs_in  = held_rhs_ff;
            job_diag_in = held_diag_ff;
            job_sub_in  = held_sub_ff;
            job_xp_in   = before_x_ff;
            job_sup_in  = held_super_ff;
            job_xn_in   = req_x_old;
            job_last_in = 1'b0;
            before_x_in = held_x_ff;
         end
         held_rhs_in    = req_rhs;
         held_diag_in   = req_diag_coef;
         held_sub_in    = req_sub_coef;
         held_super_in  = req_super_coef;
         held_x_in      = req_x_old;
         row_pending_in = !req_last_row;
         tail_in        = req_last_row;
      end

      case (state_ff)
         ST_LOAD: begin
            // final row of the vector: no super term
            job_rhs_in  = held_rhs_ff;
            job_diag_in = held_diag_ff;
            job_sub_in  = held_sub_ff;
            job_xp_in   = before_x_ff;
            job_sup_in  = '0;
            job_xn_in   = '0;
            job_last_in = 1'b1;
            before_x_in = '0;
            tail_in     = 1'b0;
         end
         ST_MUL_SUB: begin
            prod_in = $signed(mul_a) * $signed(mul_b);
         end
         ST_MUL_SUP: begin
            p_sub_in = sat_prod(prod_ff);
            prod_in  = $signed(mul_a) * $signed(mul_b);
         end
         ST_SUM: begin
            num_in = $signed({{(NUM_W-DATA_W){job_rhs_ff[DATA_W-1]}}, job_rhs_ff})
                   - $signed({{(NUM_W-DATA_W){p_sub_ff[DATA_W-1]}}, p_sub_ff})
                   - $signed({{(NUM_W-DATA_W){p_sup[DATA_W-1]}}, p_sup});
         end
         ST_SETUP: begin
            dm_in  = dm_calc;
            neg_in = num_ff[NUM_W-1] ^ job_diag_ff[DATA_W-1];
            zd_in  = (job_diag_ff == '0);
            ovf_in = ({{(DATA_W-TOP_W){1'b0}}, top} >= dm_calc);
            rem_in = {{(DATA_W-TOP_W){1'b0}}, top};
            low_in = dvd[QUO_W-1:0];
            quo_in = '0;
            cnt_in = CNT_W'(QUO_W - 1);
         end
         ST_DIV: begin
            if (!trial[TRIAL_W-1]) begin
               rem_in = trial[DATA_W-1:0];
            end else begin
               rem_in = {rem_ff[DATA_W-2:0], low_ff[QUO_W-1]};
            end
            quo_in = {quo_ff[QUO_W-2:0], !trial[TRIAL_W-1]};
            low_in = {low_ff[QUO_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in     = 1'b1;
         rsp_x_new_in     = result;
         rsp_zero_diag_in = zd_ff;
         rsp_last_out_in  = job_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_pending_ff <= 1'b0;
         tail_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         before_x_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         row_pending_ff <= row_pending_in;
         tail_ff        <= tail_in;
         rsp_valid_ff   <= rsp_valid_in;
         before_x_ff    <= before_x_in;
      end
   end

   always_ff @(posedge clock) begin
      held_rhs_ff      <= held_rhs_in;
      held_diag_ff     <= held_diag_in;
      held_sub_ff      <= held_sub_in;
      held_super_ff    <= held_super_in;
      held_x_ff        <= held_x_in;
      job_rhs_ff       <= job_rhs_in;
      job_diag_ff      <= job_diag_in;
      job_sub_ff       <= job_sub_in;
      job_xp_ff        <= job_xp_in;
      job_sup_ff       <= job_sup_in;
      job_xn_ff        <= job_xn_in;
      job_last_ff      <= job_last_in;
      prod_ff          <= prod_in;
      p_sub_ff         <= p_sub_in;
      num_ff           <= num_in;
      rem_ff           <= rem_in;
      dm_ff            <= dm_in;
      low_ff           <= low_in;
      quo_ff           <= quo_in;
      cnt_ff           <= cnt_in;
      neg_ff           <= neg_in;
      ovf_ff           <= ovf_in;
      zd_ff            <= zd_in;
      rsp_x_new_ff     <= rsp_x_new_in;
      rsp_zero_diag_ff <= rsp_zero_diag_in;
      rsp_last_out_ff  <= rsp_last_out_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_new     = rsp_x_new_ff;
   assign rsp_zero_diag = rsp_zero_diag_ff;
   assign rsp_last_out  = rsp_last_out_ff;

`ifndef NO_ASSERTIONS
   a_tail_excl: assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> !row_pending_ff)
      else $error("tail word pending while a row is still held");

   a_before_clear: assert property (@(posedge clock) disable iff (reset)
      (!row_pending_ff && !tail_ff) |-> (before_x_ff == '0))
      else $error("previous estimate not cleared between vectors");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response loaded outside the final step");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dm_ff))
      else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

/* tb/sv/tridiagonal_jacobi_sweep_tb.sv */
`timescale 1ns / 1ps

module tridiagonal_jacobi_sweep_tb import tjs_pkg::*;;

   localparam logic [DATA_W-1:0] ONE_Q      = 32'h0001_0000;
   localparam logic [DATA_W-1:0] MINUS_ONE  = 32'hFFFF_FFFF;
   localparam int                TARGET     = 450;
   localparam int                IDLE_LIMIT = 3000;
   localparam int                DRAIN      = 80;

   typedef struct packed {
      logic [DATA_W-1:0] x_new;
      logic              zero_diag;
      logic              last_out;
   } row_estimate_type;

   class jacobi_board;
      logic [DATA_W-1:0] held_rhs, held_diag, held_sub, held_super, held_x, prev_x;
      bit                row_held;
      bit                new_vector;
      row_estimate_type  estimates_q[$];
      int                errors;

      function new();
         held_rhs   = '0;
         held_diag  = '0;
         held_sub   = '0;
         held_super = '0;
         held_x     = '0;
         prev_x     = '0;
         row_held   = 1'b0;
         new_vector = 1'b1;
         errors     = 0;
      endfunction

      // floor(a*b / 2^FRAC_BITS), clamped to 32 bits
      function longint scaled_product(logic signed [DATA_W-1:0] a,
                                      logic signed [DATA_W-1:0] b);
         longint p;
         p = (longint'(a) * longint'(b)) >>> FRAC_BITS;
         if (p > longint'($signed(DATA_MAX))) return longint'($signed(DATA_MAX));
         if (p < longint'($signed(DATA_MIN))) return longint'($signed(DATA_MIN));
         return p;
      endfunction

      function row_estimate_type solve_row(logic signed [DATA_W-1:0] rhs,
                                           logic signed [DATA_W-1:0] diag,
                                           logic signed [DATA_W-1:0] sub,
                                           logic signed [DATA_W-1:0] xp,
                                           logic signed [DATA_W-1:0] sup,
                                           logic signed [DATA_W-1:0] xn,
                                           logic last);
         row_estimate_type r;
         longint         num;
         longint         dv;
         longint unsigned nm, dm, qm;
         bit             neg;
         r.x_new     = '0;
         r.zero_diag = 1'b0;
         r.last_out  = last;
         if (diag == 0) begin
            r.zero_diag = 1'b1;
            return r;
         end
         num = longint'(rhs) - scaled_product(sub, xp) - scaled_product(sup, xn);
         dv  = longint'(diag);
         neg = (num < 0) != (dv < 0);
         nm  = (num < 0) ? longint'(-num) : num;
         nm  = nm << FRAC_BITS;
         dm  = (dv < 0) ? longint'(-dv) : dv;
         qm  = nm / dm;
         if (neg) begin
            if (qm > 64'd2147483648) begin
               r.x_new = DATA_MIN;
            end else begin
               qm      = ~qm + 64'd1;
               r.x_new = qm[DATA_W-1:0];
            end
         end else begin
            r.x_new = (qm > 64'd2147483647) ? DATA_MAX : qm[DATA_W-1:0];
         end
         return r;
      endfunction

      function void note_row(logic [DATA_W-1:0] rhs, logic [DATA_W-1:0] diag,
                             logic [DATA_W-1:0] sub, logic [DATA_W-1:0] sup,
                             logic [DATA_W-1:0] x, logic last);
         if (row_held) begin
            estimates_q.push_back(solve_row(held_rhs, held_diag, held_sub, prev_x,
                                            held_super, x, 1'b0));
            prev_x = held_x;
         end
         if (new_vector) prev_x = '0;
         if (last) begin
            estimates_q.push_back(solve_row(rhs, diag, sub, prev_x, '0, '0, 1'b1));
            row_held   = 1'b0;
            new_vector = 1'b1;
            prev_x     = '0;
         end else begin
            held_rhs   = rhs;
            held_diag  = diag;
            held_sub   = sub;
            held_super = sup;
            held_x     = x;
            row_held   = 1'b1;
            new_vector = 1'b0;
         end
      endfunction

      function void check_estimate(logic [DATA_W-1:0] x_new, logic zero_diag,
                                   logic last_out);
         row_estimate_type want;
         if (estimates_q.size() == 0) begin
            $display("%0t: unexpected response x_new %h zero_diag %b last_out %b",
                     $time, x_new, zero_diag, last_out);
            errors++;
            return;
         end
         want = estimates_q.pop_front();
         if (x_new !== want.x_new) begin
            $display("%0t: x_new expected %h actual %h", $time, want.x_new, x_new);
            errors++;
         end
         if (zero_diag !== want.zero_diag) begin
            $display("%0t: zero_diag expected %b actual %b", $time, want.zero_diag,
                     zero_diag);
            errors++;
         end
         if (last_out !== want.last_out) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last_out,
                     last_out);
            errors++;
         end
      endfunction

      function int pending();
         return estimates_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_rhs = '0;
   logic [DATA_W-1:0] req_diag_coef = '0;
   logic [DATA_W-1:0] req_sub_coef = '0;
   logic [DATA_W-1:0] req_super_coef = '0;
   logic [DATA_W-1:0] req_x_old = '0;
   logic              req_last_row = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_x_new;
   logic              rsp_zero_diag;
   logic              rsp_last_out;

   jacobi_board sb;
   bit          quiet = 1'b0;
   int          rows_sent = 0;
   int          idle_cycles = 0;

   tridiagonal_jacobi_sweep dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_row(req_rhs, req_diag_coef, req_sub_coef, req_super_coef, req_x_old,
                     req_last_row);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_estimate(rsp_x_new, rsp_zero_diag, rsp_last_out);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tridiagonal_jacobi_sweep: mismatch");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 15);
      if (r < 11) return $urandom_range(0, 3);
      if (r < 15) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_W-1:0] rand_q();
      logic [19:0] s;
      s = 20'($urandom);
      case ($urandom_range(0, 9))
         0: return DATA_MIN;
         1: return DATA_MAX;
         2: return '0;
         3: return MINUS_ONE;
         4, 5: return {{12{s[19]}}, s};
         default: return $urandom;
      endcase
   endfunction

   initial begin
      forever begin
         int n;
         @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   task automatic send_row(input logic [DATA_W-1:0] rhs, input logic [DATA_W-1:0] diag,
                           input logic [DATA_W-1:0] sub, input logic [DATA_W-1:0] sup,
                           input logic [DATA_W-1:0] x, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rhs        <= rhs;
      req_diag_coef  <= diag;
      req_sub_coef   <= sub;
      req_super_coef <= sup;
      req_x_old      <= x;
      req_last_row   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rows_sent++;
   endtask

   initial begin
      int len;
      logic [DATA_W-1:0] d;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single-row vectors: sub and super both dropped
      send_row(DATA_MAX, ONE_Q, DATA_MAX, DATA_MAX, DATA_MIN, 1'b1);
      send_row(DATA_MIN, '0, DATA_MIN, DATA_MIN, DATA_MAX, 1'b1);
      send_row(DATA_MIN, MINUS_ONE, '0, '0, '0, 1'b1);
      send_row(DATA_MAX, 32'h0000_0001, '0, '0, '0, 1'b1);
      send_row(DATA_MIN, 32'h0000_0001, '0, '0, '0, 1'b1);
      // extremes, zero diagonal mid-vector, ignored first sub and last super
      send_row(DATA_MIN, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MAX, 1'b0);
      send_row('0, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MIN, 1'b0);
      send_row(32'h0003_0000, '0, DATA_MAX, DATA_MIN, DATA_MAX, 1'b0);
      send_row(DATA_MAX, MINUS_ONE, DATA_MAX, DATA_MAX, DATA_MAX, 1'b1);
      // floor rounding of tiny negative products
      send_row(32'h0000_0005, ONE_Q, MINUS_ONE, MINUS_ONE, 32'h0000_0001, 1'b0);
      send_row(32'hFFFF_FFF0, ONE_Q, MINUS_ONE, MINUS_ONE, 32'h0000_0001, 1'b1);
      // ordinary diagonally dominant system
      send_row(32'h0001_8000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000, 1'b0);
      send_row(32'hFFFE_0000, 32'hFFFC_0000, 32'h0000_8000, 32'h0000_C000, 32'hFFFF_8000, 1'b0);
      send_row(32'h0002_4000, 32'h0003_0000, 32'hFFFF_4000, 32'h0001_0000, 32'h0001_2000, 1'b1);

      while (rows_sent < TARGET) begin
         len   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(6, 24);
         quiet = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < len; i++) begin
            d = ($urandom_range(0, 11) == 0) ? '0 : rand_q();
            send_row(rand_q(), d, rand_q(), rand_q(), rand_q(), i == len - 1);
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tridiagonal_jacobi_sweep: match");
      end else begin
         $display("tridiagonal_jacobi_sweep: mismatch");
      end
      $finish;
   end

endmodule

/* sim.f */
src/tjs_pkg.sv
src/tridiagonal_jacobi_sweep.sv
tb/sv/tridiagonal_jacobi_sweep_tb.sv
